[rtl/msma_pkg.sv]
// ----------------------------------------------------------------------------
// msma_pkg: shared types and arithmetic for the modular multiply-add block
// Holds the word width, the request types of both channels, the register
// indexes of the configuration port and the per-stage pipeline records.
// ----------------------------------------------------------------------------
`default_nettype none

package msma_pkg;

  localparam int WORD_BITS      = 64;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALAR  = CFG_INDEX_BITS'(1);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t acc_value;
    word_t element;
    logic  last_in;
  } item_t;

  typedef struct packed {
    word_t sum_value;
    logic  last_out;
  } result_t;

  // One step of the operand reduction: both words are shifted out MSB first
  // into their remainders.
  typedef struct packed {
    logic  valid;
    logic  last;
    word_t acc_word;
    word_t elem_word;
    word_t acc_rem;
    word_t elem_rem;
  } red_stage_t;

  // One step of the double-and-add multiplication.
  typedef struct packed {
    logic  valid;
    logic  last;
    word_t acc_red;
    word_t addend;
    word_t prod;
  } mac_stage_t;

  // (a + b) mod n for a, b below n. With n equal to zero both arms give the
  // plain wrapped sum, which is the full-word ring.
  function automatic word_t add_mod(word_t a, word_t b, word_t n);
    word_t room;
    word_t res;
    room = n - b;
    if (a >= room) begin
      res = a - room;
    end else begin
      res = a + b;
    end
    return res;
  endfunction

  // Restoring remainder step: shift one bit into rem and take n off once.
  // With n equal to zero the remainder simply collects the word.
  function automatic word_t reduce_step(word_t rem, logic shift_in, word_t n);
    logic [WORD_BITS:0] t;
    t = {rem, shift_in};
    if (t >= {1'b0, n}) begin
      t = t - {1'b0, n};
    end
    return t[WORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/msma_reduce_stage.sv]
// ----------------------------------------------------------------------------
// msma_reduce_stage: one bit of the operand reduction
// Reduces the accumulator and the element modulo the modulus in parallel,
// one bit of each per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module msma_reduce_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  msma_pkg::word_t       modulus,
  input  msma_pkg::red_stage_t  stage_in,
  output msma_pkg::red_stage_t  stage_out
);

  // Only the valid bit is reset; the data fields follow the valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out.valid <= stage_in.valid;
    end
    if (advance) begin
      stage_out.last      <= stage_in.last;
      stage_out.acc_word  <= stage_in.acc_word << 1;
      stage_out.elem_word <= stage_in.elem_word << 1;
      stage_out.acc_rem   <= msma_pkg::reduce_step(stage_in.acc_rem,
                               stage_in.acc_word[msma_pkg::WORD_BITS-1], modulus);
      stage_out.elem_rem  <= msma_pkg::reduce_step(stage_in.elem_rem,
                               stage_in.elem_word[msma_pkg::WORD_BITS-1], modulus);
    end
  end

endmodule

`default_nettype wire

[rtl/msma_mac_stage.sv]
// ----------------------------------------------------------------------------
// msma_mac_stage: one step of the modular double-and-add multiplier
// Either doubles the running product or adds the reduced element to it,
// always modulo the modulus; with neither selected it passes the product on.
// ----------------------------------------------------------------------------
`default_nettype none

module msma_mac_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  msma_pkg::word_t       modulus,
  input  logic                  dbl,
  input  logic                  take,
  input  msma_pkg::mac_stage_t  stage_in,
  output msma_pkg::mac_stage_t  stage_out
);

  msma_pkg::word_t operand;
  msma_pkg::word_t prod_next;

  always_comb begin
    operand = dbl ? stage_in.prod : stage_in.addend;
    if (dbl || take) begin
      prod_next = msma_pkg::add_mod(stage_in.prod, operand, modulus);
    end else begin
      prod_next = stage_in.prod;
    end
  end

  // Only the valid bit is reset; the data fields follow the valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out.valid <= stage_in.valid;
    end
    if (advance) begin
      stage_out.last    <= stage_in.last;
      stage_out.acc_red <= stage_in.acc_red;
      stage_out.addend  <= stage_in.addend;
      stage_out.prod    <= prod_next;
    end
  end

endmodule

`default_nettype wire

[rtl/modular_scalar_multiply_add.sv]
// ----------------------------------------------------------------------------
// modular_scalar_multiply_add: streaming (acc + element * scalar) mod modulus
// Fully pipelined modular multiply-accumulate over a vector, one element per
// cycle while not stalled, with modulus and scalar in configuration registers.
// ----------------------------------------------------------------------------
// How to use this block:
// Write the modulus (index CFG_MODULUS) and the scalar (index CFG_SCALAR)
// through the cfg_write port while no request is in flight. Then stream the
// vector on the item channel; each request carries an accumulator word, an
// element and a last flag. Every request yields exactly one result request
// with sum_value = (acc_value + element * scalar) mod modulus and the last
// flag copied through. A modulus of zero selects plain wrap-around arithmetic.
// Throughput is one request per cycle unless the receiver stalls. WORD_BITS
// stages reduce both operands one bit each, 2 * WORD_BITS stages run the
// double-and-add multiplier over the scalar bits, and the output register does
// the final modular addition.
// Reset clears every valid bit, sets the modulus to one and the scalar to zero.
// When the receiver stalls while a result is held, the whole pipeline freezes
// and item_stall rises in the same cycle; nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_scalar_multiply_add (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [msma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  msma_pkg::word_t                       cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  msma_pkg::item_t                       item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output msma_pkg::result_t                     result
);

  localparam int MAC_STAGES = 2 * msma_pkg::WORD_BITS;

  msma_pkg::word_t      modulus;
  msma_pkg::word_t      scalar;
  logic                 advance;
  msma_pkg::red_stage_t red_chain [msma_pkg::WORD_BITS+1];
  msma_pkg::mac_stage_t mac_chain [MAC_STAGES+1];

  // Configuration registers. Writes to indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= msma_pkg::word_t'(1);
      scalar  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        msma_pkg::CFG_MODULUS: modulus <= cfg_data;
        msma_pkg::CFG_SCALAR:  scalar  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one: it holds only when the output register is
  // full and the receiver stalls it.
  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;

  // Entry into the reduction chain: remainders start at zero and the words
  // are shifted in MSB first.
  always_comb begin
    red_chain[0].valid     = item_valid;
    red_chain[0].last      = item.last_in;
    red_chain[0].acc_word  = item.acc_value;
    red_chain[0].elem_word = item.element;
    red_chain[0].acc_rem   = '0;
    red_chain[0].elem_rem  = '0;
  end

  for (genvar k = 0; k < msma_pkg::WORD_BITS; k++) begin : g_reduce
    msma_reduce_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .modulus   (modulus),
      .stage_in  (red_chain[k]),
      .stage_out (red_chain[k+1])
    );
  end

  // The reduced element becomes the addend, the product starts at zero.
  always_comb begin
    mac_chain[0].valid   = red_chain[msma_pkg::WORD_BITS].valid;
    mac_chain[0].last    = red_chain[msma_pkg::WORD_BITS].last;
    mac_chain[0].acc_red = red_chain[msma_pkg::WORD_BITS].acc_rem;
    mac_chain[0].addend  = red_chain[msma_pkg::WORD_BITS].elem_rem;
    mac_chain[0].prod    = '0;
  end

  // Even stages double the product, odd stages add the element when the
  // matching scalar bit is set, walking the scalar from its MSB down.
  for (genvar j = 0; j < msma_pkg::WORD_BITS; j++) begin : g_mac
    msma_mac_stage u_double (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .modulus   (modulus),
      .dbl       (1'b1),
      .take      (1'b0),
      .stage_in  (mac_chain[2*j]),
      .stage_out (mac_chain[2*j+1])
    );
    msma_mac_stage u_add (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .modulus   (modulus),
      .dbl       (1'b0),
      .take      (scalar[msma_pkg::WORD_BITS-1-j]),
      .stage_in  (mac_chain[2*j+1]),
      .stage_out (mac_chain[2*j+2])
    );
  end

  // Output register: the final modular addition of the reduced accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= mac_chain[MAC_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.sum_value <= msma_pkg::add_mod(mac_chain[MAC_STAGES].acc_red,
                                            mac_chain[MAC_STAGES].prod, modulus);
      result.last_out  <= mac_chain[MAC_STAGES].last;
    end
  end

`ifndef SYNTH
  // The input side is only held back by a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("item_stall raised without a stalled result");

  // No result is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid set right after reset");

  // A frozen pipeline keeps its tail stage unchanged.
  a_tail_frozen: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(mac_chain[MAC_STAGES].valid) &&
                  $stable(mac_chain[MAC_STAGES].prod)))
    else $error("multiplier tail moved while the pipeline was held");

  // A held result does not lose its valid bit.
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire
